// ===== rtl/core/satl_pkg.sv =====
// ----------------------------------------------------------------------------
// satl_pkg
// Shared types, constants and width helpers for the set-associative tag
// lookup with tree pseudo-LRU replacement.
// ----------------------------------------------------------------------------
package satl_pkg;

   localparam int TagW         = 32;
   localparam int WayW         = 6;
   localparam int OffW         = 4;
   localparam int DEF_NUM_SETS = 64;
   localparam int DEF_NUM_WAYS = 8;

   localparam logic [TagW-1:0] TAG_RESET    = 32'hA000_0000;
   localparam logic [OffW-1:0] OFFSET_RESET = 4'd4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic            hit;
      logic [WayW-1:0] way;
   } eval_result_type;

   // index width for a store of n entries, at least one bit
   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic int floor_log2(input int n);
      return $clog2(n + 1) - 1;
   endfunction

endpackage

// ===== rtl/core/set_assoc_tag_lookup_tree_plru_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_tag_lookup_tree_plru_unit
// Set-associative tag lookup with tree pseudo-LRU replacement: hit or miss
// and the way used for each address.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. Each access goes
// through tag shift, set row read, and compare and write-back when NUM_SETS
// is a power of two; otherwise the set number also passes through registered
// steps for a multiply by the reciprocal of NUM_SETS and a subtract. The tag
// and tree memories have one port each way, so busy stays high until the row
// is written back. The result shows on rsp_strobe for exactly one cycle, in
// the cycle after the write-back, and cannot be held off. After reset a
// clearing pass writes every set with busy high; csr writes are taken
// meanwhile.
module set_assoc_tag_lookup_tree_plru_unit #(
   parameter int NUM_SETS = satl_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS = satl_pkg::DEF_NUM_WAYS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [satl_pkg::TagW-1:0] req_address,
   output logic                      rsp_strobe,
   output logic                      rsp_hit,
   output logic [satl_pkg::WayW-1:0] rsp_way,
   input  logic                      csr_wr_en,
   input  logic [satl_pkg::OffW-1:0] csr_wr_data
);

   localparam int SetW  = satl_pkg::idx_width(NUM_SETS);
   localparam int PlruW = (NUM_WAYS > 1) ? NUM_WAYS - 1 : 1;
   localparam int TagW  = satl_pkg::TagW;

   satl_pkg::state_type state_ff;
   satl_pkg::state_type state_in;

   logic [satl_pkg::OffW-1:0] offset_ff;
   logic [SetW-1:0]           clr_ff;
   logic                      last_clear;

   logic                      accept;
   logic                      idx_done;
   logic [TagW-1:0]           idx_tag;
   logic [SetW-1:0]           idx_set;

   logic                              rd_en;
   logic [NUM_WAYS-1:0][TagW:0]       rd_row;
   logic [PlruW-1:0]                  rd_plru;
   logic                              wr_en;
   logic [SetW-1:0]                   wr_addr;
   logic [NUM_WAYS-1:0][TagW:0]       wr_row;
   logic [PlruW-1:0]                  wr_plru;
   logic [NUM_WAYS-1:0][TagW:0]       eval_row;
   logic [PlruW-1:0]                  eval_plru;
   logic [NUM_WAYS-1:0][TagW:0]       clear_row;
   satl_pkg::eval_result_type         eval_result;

   logic                      rsp_strobe_ff;
   logic                      rsp_strobe_in;
   logic                      rsp_hit_ff;
   logic [satl_pkg::WayW-1:0] rsp_way_ff;

   assign last_clear = (clr_ff == SetW'(NUM_SETS - 1));

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         clear_row[w] = {1'b0, satl_pkg::TAG_RESET};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         satl_pkg::ST_CLEAR: begin
            if (last_clear) begin
               state_in = satl_pkg::ST_IDLE;
            end
         end
         satl_pkg::ST_IDLE: begin
            if (start) begin
               state_in = satl_pkg::ST_INDEX;
            end
         end
         satl_pkg::ST_INDEX: begin
            if (idx_done) begin
               state_in = satl_pkg::ST_EVAL;
            end
         end
         satl_pkg::ST_EVAL: begin
            state_in = satl_pkg::ST_IDLE;
         end
         default: begin
            state_in = satl_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy          = 1'b1;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_set;
      wr_row        = eval_row;
      wr_plru       = eval_plru;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         satl_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_row  = clear_row;
            wr_plru = '0;
         end
         satl_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         satl_pkg::ST_INDEX: begin
            rd_en = idx_done;
         end
         satl_pkg::ST_EVAL: begin
            wr_en         = 1'b1;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= satl_pkg::ST_CLEAR;
         clr_ff        <= '0;
         offset_ff     <= satl_pkg::OFFSET_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (state_ff == satl_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_hit_ff <= eval_result.hit;
         rsp_way_ff <= eval_result.way;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_way    = rsp_way_ff;

   satl_set_index #(
      .NUM_SETS (NUM_SETS)
   ) u_set_index (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .address   (req_address),
      .offset    (offset_ff),
      .tag       (idx_tag),
      .set_index (idx_set),
      .done      (idx_done)
   );

   satl_store #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (idx_set),
      .rd_row  (rd_row),
      .rd_plru (rd_plru),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row),
      .wr_plru (wr_plru)
   );

   satl_way_eval #(
      .NUM_WAYS (NUM_WAYS)
   ) u_way_eval (
      .tag      (idx_tag),
      .row_in   (rd_row),
      .plru_in  (rd_plru),
      .result   (eval_result),
      .row_out  (eval_row),
      .plru_out (eval_plru)
   );

endmodule

// ===== rtl/core/satl_set_index.sv =====
// ----------------------------------------------------------------------------
// satl_set_index
// Forms the tag from the byte address and reduces it to a set number, by a
// mask for a power-of-two set count or a multiply by the reciprocal otherwise.
// ----------------------------------------------------------------------------
module satl_set_index #(
   parameter int NUM_SETS = satl_pkg::DEF_NUM_SETS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic [satl_pkg::TagW-1:0]                address,
   input  logic [satl_pkg::OffW-1:0]                offset,
   output logic [satl_pkg::TagW-1:0]                tag,
   output logic [satl_pkg::idx_width(NUM_SETS)-1:0] set_index,
   output logic                                     done
);

   localparam int SetW  = satl_pkg::idx_width(NUM_SETS);
   localparam int ProdW = satl_pkg::TagW + 33;

   logic [satl_pkg::TagW-1:0] tag_ff;
   logic                      done_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tag_ff <= address >> offset;
      end
   end

   assign tag  = tag_ff;
   assign done = done_ff;

   if (NUM_SETS == 1) begin : g_single
      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= load;
         end
      end

      assign set_index = '0;
   end else if ((1 << SetW) == NUM_SETS) begin : g_mask
      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= load;
         end
      end

      assign set_index = tag_ff[SetW-1:0];
   end else begin : g_recip
      localparam logic [ProdW-1:0] Scale   = ProdW'(1) << (satl_pkg::TagW + SetW);
      localparam logic [ProdW-1:0] Recip   =
         (Scale + ProdW'(NUM_SETS) - ProdW'(1)) / ProdW'(NUM_SETS);
      localparam logic [SetW-1:0]  SetsLow = SetW'(NUM_SETS);

      logic [ProdW-1:0] product;
      logic [SetW-1:0]  quot_in;
      logic [SetW-1:0]  quot_ff;
      logic [SetW-1:0]  rem_in;
      logic [SetW-1:0]  rem_ff;
      logic             mul_ff;
      logic             sub_ff;

      // rounded-up reciprocal gives the exact quotient for any 32-bit tag
      assign product = ProdW'(tag_ff) * Recip;
      assign quot_in = product[satl_pkg::TagW+SetW +: SetW];
      // remainder is below the set count, so its low bits are enough
      assign rem_in  = tag_ff[SetW-1:0] - quot_ff * SetsLow;

      always_ff @(posedge clock) begin
         if (reset) begin
            mul_ff  <= 1'b0;
            sub_ff  <= 1'b0;
            done_ff <= 1'b0;
         end else begin
            mul_ff  <= load;
            sub_ff  <= mul_ff;
            done_ff <= sub_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (mul_ff) begin
            quot_ff <= quot_in;
         end
         if (sub_ff) begin
            rem_ff <= rem_in;
         end
      end

      assign set_index = rem_ff;
   end

endmodule

// ===== rtl/core/satl_store.sv =====
// ----------------------------------------------------------------------------
// satl_store
// Tag memory, one row of valid and tag per way for each set, and tree bit
// memory, one word per set. Synchronous read with registered data.
// ----------------------------------------------------------------------------
module satl_store #(
   parameter int NUM_SETS = satl_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS = satl_pkg::DEF_NUM_WAYS
) (
   input  logic                                          clock,
   input  logic                                          rd_en,
   input  logic [satl_pkg::idx_width(NUM_SETS)-1:0]      rd_addr,
   output logic [NUM_WAYS-1:0][satl_pkg::TagW:0]         rd_row,
   output logic [((NUM_WAYS > 1) ? NUM_WAYS - 1 : 1)-1:0] rd_plru,
   input  logic                                          wr_en,
   input  logic [satl_pkg::idx_width(NUM_SETS)-1:0]      wr_addr,
   input  logic [NUM_WAYS-1:0][satl_pkg::TagW:0]         wr_row,
   input  logic [((NUM_WAYS > 1) ? NUM_WAYS - 1 : 1)-1:0] wr_plru
);

   localparam int PlruW = (NUM_WAYS > 1) ? NUM_WAYS - 1 : 1;

   logic [NUM_WAYS-1:0][satl_pkg::TagW:0] tag_mem [NUM_SETS];
   logic [PlruW-1:0]                      plru_mem [NUM_SETS];

   logic [NUM_WAYS-1:0][satl_pkg::TagW:0] rd_row_ff;
   logic [PlruW-1:0]                      rd_plru_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr]  <= wr_row;
         plru_mem[wr_addr] <= wr_plru;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff  <= tag_mem[rd_addr];
         rd_plru_ff <= plru_mem[rd_addr];
      end
   end

   assign rd_row  = rd_row_ff;
   assign rd_plru = rd_plru_ff;

endmodule

// ===== rtl/core/satl_way_eval.sv =====
// ----------------------------------------------------------------------------
// satl_way_eval
// Compares the tag against every way of the set, walks the tree for a
// victim on a miss and forms the updated row and tree bits.
// ----------------------------------------------------------------------------
module satl_way_eval #(
   parameter int NUM_WAYS = satl_pkg::DEF_NUM_WAYS
) (
   input  logic [satl_pkg::TagW-1:0]                      tag,
   input  logic [NUM_WAYS-1:0][satl_pkg::TagW:0]          row_in,
   input  logic [((NUM_WAYS > 1) ? NUM_WAYS - 1 : 1)-1:0] plru_in,
   output satl_pkg::eval_result_type                      result,
   output logic [NUM_WAYS-1:0][satl_pkg::TagW:0]          row_out,
   output logic [((NUM_WAYS > 1) ? NUM_WAYS - 1 : 1)-1:0] plru_out
);

   localparam int TagW    = satl_pkg::TagW;
   localparam int WayIdxW = satl_pkg::idx_width(NUM_WAYS);
   localparam int Levels  = satl_pkg::floor_log2(NUM_WAYS);
   localparam int LeafW   = Levels + 1;

   logic               hit;
   logic [WayIdxW-1:0] hit_way;
   logic [WayIdxW-1:0] victim;
   logic [WayIdxW-1:0] sel_way;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row_in[w][TagW] && (row_in[w][TagW-1:0] == tag)) begin
            hit     = 1'b1;
            hit_way = WayIdxW'(w);
         end
      end
      sel_way = hit ? hit_way : victim;
   end

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_out[w] = row_in[w];
         if (!hit && (victim == WayIdxW'(w))) begin
            row_out[w] = {1'b1, tag};
         end
      end
   end

   assign result.hit = hit;
   assign result.way = satl_pkg::WayW'(sel_way);

   if (Levels == 0) begin : g_flat
      assign victim   = '0;
      assign plru_out = plru_in;
   end else begin : g_tree
      always_comb begin : victim_walk
         logic [LeafW-1:0] node;
         logic             dir;
         node = LeafW'(1);
         for (int lvl = 0; lvl < Levels; lvl++) begin
            dir = 1'b0;
            for (int n = 1; n < (1 << Levels); n++) begin
               if (node == LeafW'(n)) begin
                  dir = plru_in[n-1];
               end
            end
            node = {node[LeafW-2:0], dir};
         end
         victim = WayIdxW'(node[Levels-1:0]);
      end

      // walking to the victim flips the same bits as pointing away from it
      always_comb begin : touch
         logic [LeafW-1:0] leaf;
         leaf     = {1'b1, sel_way[Levels-1:0]};
         plru_out = plru_in;
         for (int n = 1; n < (1 << Levels); n++) begin
            if ((leaf >> (Levels - satl_pkg::floor_log2(n))) == LeafW'(n)) begin
               plru_out[n-1] = ~leaf[Levels-satl_pkg::floor_log2(n)-1];
            end
         end
      end
   end

endmodule
